// ===== hdl/hsj_pkg.sv =====
// ----------------------------------------------------------------------------
// hsj_pkg: shared types and constants of the heat stencil step
// Payload structs, queue entry, register indexes and fixed-point widths.
// ----------------------------------------------------------------------------
`default_nettype none

package hsj_pkg;

	// fixed-point widths
	localparam int SAMPLE_W  = 16;  // signed Q8.8 sample
	localparam int POS_W     = 10;  // stored row / column position
	localparam int COL_W     = 11;  // position with room for the wrap compare
	localparam int GAIN_W    = 16;  // unsigned Q1.15
	localparam int CFG_W     = 16;  // widest register
	localparam int LAP_W     = 19;  // N+S+E+W-4C
	localparam int PROD_W    = 36;  // lap * gain, Q.23
	localparam int DELTA_W   = 22;  // scaled delta and sum before saturation
	localparam int FRAC_BITS = 15;

	// input queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// configuration register indexes
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_GRID_SIZE = 1'b0;
	localparam cfg_index_t CFG_GAIN      = 1'b1;

	localparam logic [POS_W-1:0]  GRID_RESET = 10'd100;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] cell_value;
		logic                       frame_start;
	} cell_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] new_value;
		logic [POS_W-1:0]           row_index;
		logic [POS_W-1:0]           col_index;
		logic                       frame_last;
	} cell_out_t;

	// classified item handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] cell_value;
		logic [COL_W-1:0]           col;
		logic                       col_zero;
		logic                       east_ok;
		logic                       emit;
		logic [POS_W-1:0]           row_index;
		logic                       frame_last;
	} work_t;

endpackage

`default_nettype wire

// ===== hdl/hsj_front.sv =====
// ----------------------------------------------------------------------------
// hsj_front: raster position tracking and item classification
// Places each accepted cell in the padded grid and tags it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hsj_front #(
	parameter int MAX_PADDED_WIDTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire hsj_pkg::cell_in_t         in_data,
	input  wire logic [hsj_pkg::POS_W-1:0] grid_size,
	input  wire logic                      q_full,
	output logic                           push,
	output hsj_pkg::work_t                 entry
);
	import hsj_pkg::*;

	logic [POS_W-1:0] cur_row_q;
	logic [POS_W-1:0] cur_col_q;

	logic [COL_W-1:0] n_eff;
	logic [COL_W-1:0] w_eff;
	logic [COL_W-1:0] r;
	logic [COL_W-1:0] c;
	logic [COL_W-1:0] r_nxt;
	logic [COL_W-1:0] c_nxt;
	logic [COL_W-1:0] row_out;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// effective grid size and padded side
	always_comb begin
		n_eff = COL_W'(grid_size);
		if (grid_size == '0) begin
			n_eff = COL_W'(1);
		end else if (int'(grid_size) > MAX_PADDED_WIDTH - 2) begin
			n_eff = COL_W'(MAX_PADDED_WIDTH - 2);
		end
		w_eff = n_eff + COL_W'(2);
	end

	// position of this cell and of the next one
	always_comb begin
		r = COL_W'(cur_row_q);
		c = COL_W'(cur_col_q);
		if (in_data.frame_start) begin
			r = '0;
			c = '0;
		end
		if (c >= w_eff) begin
			c = '0;
			r = r + COL_W'(1);
		end
		if (r >= w_eff) begin
			r = '0;
		end

		r_nxt = r;
		c_nxt = c + COL_W'(1);
		if (c_nxt >= w_eff) begin
			c_nxt = '0;
			r_nxt = r + COL_W'(1);
			if (r_nxt >= w_eff) begin
				r_nxt = '0;
			end
		end
		row_out = r - COL_W'(1);
	end

	// classification
	always_comb begin
		entry.cell_value = in_data.cell_value;
		entry.col        = c;
		entry.col_zero   = (c == '0);
		entry.east_ok    = ((c + COL_W'(1)) < w_eff);
		entry.emit       = (r >= COL_W'(2)) && (c >= COL_W'(1)) && (c <= n_eff);
		entry.row_index  = POS_W'(row_out);
		entry.frame_last = (row_out == n_eff) && (c == n_eff);
	end

	// position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (push) begin
			cur_row_q <= POS_W'(r_nxt);
			cur_col_q <= POS_W'(c_nxt);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hsj_queue.sv =====
// ----------------------------------------------------------------------------
// hsj_queue: short queue between front and back
// Register-based FIFO of classified items; head is shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module hsj_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire hsj_pkg::work_t push_data,
	input  wire logic           pop,
	output logic                full,
	output logic                head_valid,
	output hsj_pkg::work_t      head
);
	import hsj_pkg::*;

	work_t             entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic do_pop;

	assign full       = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hsj_back.sv =====
// ----------------------------------------------------------------------------
// hsj_back: line buffers and stencil arithmetic
// Reads the line buffers, forms the Laplacian, scales, rounds and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module hsj_back #(
	parameter int MAX_PADDED_WIDTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [hsj_pkg::GAIN_W-1:0] gain,
	input  wire logic                       head_valid,
	input  wire hsj_pkg::work_t             head,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output hsj_pkg::cell_out_t              out_data
);
	import hsj_pkg::*;

	localparam int AW = $clog2(MAX_PADDED_WIDTH);
	localparam logic signed [DELTA_W-1:0] SAT_HI = DELTA_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [DELTA_W-1:0] SAT_LO = DELTA_W'(-(2 ** (SAMPLE_W - 1)));
	localparam logic signed [PROD_W-1:0]  ROUND_BIAS = PROD_W'(2 ** (FRAC_BITS - 1));

	// line buffers: padded rows r-1 and r-2
	logic signed [SAMPLE_W-1:0] line_middle [MAX_PADDED_WIDTH];
	logic signed [SAMPLE_W-1:0] line_above  [MAX_PADDED_WIDTH];

	logic adv;
	logic [AW-1:0] addr_c;
	logic [AW-1:0] addr_e;
	logic [AW-1:0] wr_addr;

	// stage 1: read data and item
	logic                       v_s1;
	work_t                      item_s1;
	logic signed [SAMPLE_W-1:0] mid_c_s1;
	logic signed [SAMPLE_W-1:0] mid_e_s1;
	logic signed [SAMPLE_W-1:0] above_c_s1;
	logic signed [SAMPLE_W-1:0] prev_center_q;

	logic signed [SAMPLE_W-1:0] center;
	logic signed [SAMPLE_W-1:0] west;
	logic signed [SAMPLE_W-1:0] east;
	logic signed [LAP_W-1:0]    lap;

	// stage 2: Laplacian
	logic                       v_s2;
	logic signed [LAP_W-1:0]    lap_s2;
	logic signed [SAMPLE_W-1:0] center_s2;
	logic [POS_W-1:0]           row_s2;
	logic [POS_W-1:0]           col_s2;
	logic                       last_s2;

	// stage 3: product
	logic                       v_s3;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [SAMPLE_W-1:0] center_s3;
	logic [POS_W-1:0]           row_s3;
	logic [POS_W-1:0]           col_s3;
	logic                       last_s3;

	logic signed [PROD_W-1:0]   rounded;
	logic signed [DELTA_W-1:0]  delta;
	logic signed [DELTA_W-1:0]  sum;
	logic signed [SAMPLE_W-1:0] sat_value;

	// stage 4: output register
	logic      out_valid_s4;
	cell_out_t out_data_s4;

	assign adv     = !out_valid_s4 || out_ready;
	assign pop     = adv;
	assign addr_c  = AW'(head.col);
	assign addr_e  = AW'(head.col + COL_W'(1));
	assign wr_addr = AW'(item_s1.col);

	// stencil operands; center is always the middle-row value at this column
	always_comb begin
		center = mid_c_s1;
		west   = item_s1.col_zero ? '0 : prev_center_q;
		east   = item_s1.east_ok ? mid_e_s1 : '0;
		lap    = LAP_W'(above_c_s1) + LAP_W'(item_s1.cell_value) + LAP_W'(west)
		       + LAP_W'(east) - (LAP_W'(center) <<< 2);
	end

	// line buffer write and read, with bypass of the write in flight
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s1) begin
				line_middle[wr_addr] <= item_s1.cell_value;
				line_above[wr_addr]  <= center;
			end
			if (head_valid) begin
				item_s1    <= head;
				mid_c_s1   <= (v_s1 && wr_addr == addr_c) ? item_s1.cell_value
				                                          : line_middle[addr_c];
				mid_e_s1   <= (v_s1 && wr_addr == addr_e) ? item_s1.cell_value
				                                          : line_middle[addr_e];
				above_c_s1 <= (v_s1 && wr_addr == addr_c) ? center
				                                          : line_above[addr_c];
			end
		end
	end

	// previous center feeds the west neighbor of the next column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_center_q <= '0;
		end else if (adv && v_s1) begin
			prev_center_q <= center;
		end
	end

	// arithmetic pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			lap_s2    <= lap;
			center_s2 <= center;
			row_s2    <= item_s1.row_index;
			col_s2    <= POS_W'(item_s1.col);
			last_s2   <= item_s1.frame_last;

			prod_s3   <= PROD_W'(lap_s2) * PROD_W'($signed({1'b0, gain}));
			center_s3 <= center_s2;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			last_s3   <= last_s2;

			out_data_s4.new_value  <= sat_value;
			out_data_s4.row_index  <= row_s3;
			out_data_s4.col_index  <= col_s3;
			out_data_s4.frame_last <= last_s3;
		end
	end

	// round half up, add to center, saturate
	always_comb begin
		rounded = prod_s3 + ROUND_BIAS;
		delta   = DELTA_W'(rounded >>> FRAC_BITS);
		sum     = DELTA_W'(center_s3) + delta;
		if (sum > SAT_HI) begin
			sat_value = SAMPLE_W'(SAT_HI);
		end else if (sum < SAT_LO) begin
			sat_value = SAMPLE_W'(SAT_LO);
		end else begin
			sat_value = SAMPLE_W'(sum);
		end
	end

	// valid chain; halo and first rows drop out after the buffer write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			out_valid_s4 <= 1'b0;
		end else if (adv) begin
			v_s1         <= head_valid;
			v_s2         <= v_s1 && item_s1.emit;
			v_s3         <= v_s2;
			out_valid_s4 <= v_s3;
		end
	end

	assign out_valid = out_valid_s4;
	assign out_data  = out_data_s4;

endmodule

`default_nettype wire

// ===== hdl/heat_stencil_jacobi_step.sv =====
// ----------------------------------------------------------------------------
// heat_stencil_jacobi_step: five-point Jacobi heat step on a streamed grid
// Path: the cell that completes a stencil passes the queue, then stages s1 to s4.
// Throughput: one cell per clock while no output stall holds the back end.
// Output stalls hold the whole back pipeline; the 4-entry queue absorbs input.
// Reset: grid_size 100, gain 0.25, position at the frame origin, pipeline empty.
// Line buffers are not cleared and hold stale data until a frame writes them.
// ----------------------------------------------------------------------------
`default_nettype none

module heat_stencil_jacobi_step #(
	parameter int MAX_PADDED_WIDTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire hsj_pkg::cell_in_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output hsj_pkg::cell_out_t              out_data,
	input  wire logic                       cfg_we,
	input  wire hsj_pkg::cfg_index_t        cfg_index,
	input  wire logic [hsj_pkg::CFG_W-1:0]  cfg_data
);
	import hsj_pkg::*;

	logic [POS_W-1:0]  grid_size_q;
	logic [GAIN_W-1:0] gain_q;

	logic  q_full;
	logic  push;
	work_t entry;
	logic  head_valid;
	work_t head;
	logic  pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_RESET;
			gain_q      <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_SIZE: grid_size_q <= cfg_data[POS_W-1:0];
				CFG_GAIN:      gain_q      <= cfg_data[GAIN_W-1:0];
			endcase
		end
	end

	hsj_front #(
		.MAX_PADDED_WIDTH(MAX_PADDED_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.grid_size(grid_size_q),
		.q_full   (q_full),
		.push     (push),
		.entry    (entry)
	);

	hsj_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	hsj_back #(
		.MAX_PADDED_WIDTH(MAX_PADDED_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (gain_q),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== verif/hsj_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsj_checker: result predictor and comparator for the heat stencil step
// Watches the cell, result and register ports, runs its own five-point
// stencil on every accepted cell and compares each accepted result with
// the oldest predicted one. Reports the failure and outstanding counts.
// ----------------------------------------------------------------------------

module hsj_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  hsj_pkg::cell_in_t         in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  hsj_pkg::cell_out_t        out_data,
	input  logic                      cfg_we,
	input  hsj_pkg::cfg_index_t       cfg_index,
	input  logic [hsj_pkg::CFG_W-1:0] cfg_data,
	output int                        mismatch_count,
	output int                        results_owed
);
	import hsj_pkg::*;

	localparam int          LINE_DEPTH    = 1024;
	localparam int          MAX_GRID      = LINE_DEPTH - 2;
	localparam logic [9:0]  GRID_AT_RESET = 10'd100;
	localparam logic [15:0] GAIN_AT_RESET = 16'd8192;
	localparam longint      SAMPLE_MAX    = 32767;
	localparam longint      SAMPLE_MIN    = -32768;

	logic [POS_W-1:0]           grid_cfg;
	logic [GAIN_W-1:0]          gain_cfg;
	logic signed [SAMPLE_W-1:0] row_up  [LINE_DEPTH];  // padded row r-2
	logic signed [SAMPLE_W-1:0] row_mid [LINE_DEPTH];  // padded row r-1
	logic signed [SAMPLE_W-1:0] held_centre;           // middle row at c-1
	logic signed [SAMPLE_W-1:0] held_east;             // middle row at c
	int                         next_row;
	int                         next_col;
	cell_out_t                  expected_cells [$];

	// one cell through the stencil; queue the update it completes, if any
	task automatic stencil_step(input cell_in_t item);
		int        eff;
		int        side;
		int        r;
		int        c;
		longint    x;
		longint    west;
		longint    centre;
		longint    east;
		longint    north;
		longint    lap;
		longint    delta;
		longint    sum;
		cell_out_t res;

		if (grid_cfg == 0) begin
			eff = 1;
		end else if (grid_cfg > MAX_GRID) begin
			eff = MAX_GRID;
		end else begin
			eff = int'(grid_cfg);
		end
		side = eff + 2;
		x = $signed(item.cell_value);

		// place the cell, wrapping a position left over from a wider grid
		r = next_row;
		c = next_col;
		if (item.frame_start) begin
			r = 0;
			c = 0;
		end
		if (c >= side) begin
			c = 0;
			r++;
		end
		if (r >= side) r = 0;

		// neighbors of the middle-row cell above this one
		if (c == 0) begin
			west = 0;
			centre = row_mid[0];
		end else begin
			west = held_centre;
			centre = held_east;
		end
		if (c + 1 < side) begin
			east = row_mid[c + 1];
		end else begin
			east = 0;
		end
		north = row_up[c];

		// interior cell: laplacian, scale with rounding, saturate
		if (r >= 2 && c >= 1 && c <= eff) begin
			lap = north + x + west + east - 4 * centre;
			delta = (lap * longint'(gain_cfg) + 16384) >>> FRAC_BITS;
			sum = centre + delta;
			if (sum > SAMPLE_MAX) begin
				sum = SAMPLE_MAX;
			end else if (sum < SAMPLE_MIN) begin
				sum = SAMPLE_MIN;
			end
			res.new_value = 16'(sum);
			res.row_index = 10'(r - 1);
			res.col_index = 10'(c);
			res.frame_last = (r - 1 == eff) && (c == eff);
			expected_cells.push_back(res);
		end

		held_centre = 16'(centre);
		held_east = 16'(east);
		row_up[c] = 16'(centre);
		row_mid[c] = item.cell_value;

		c++;
		if (c >= side) begin
			c = 0;
			r++;
			if (r >= side) r = 0;
		end
		next_row = r;
		next_col = c;
	endtask

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			$error("%s: expected %0h, got %0h", field, want, got);
		end
	endtask

	task automatic check_result(input cell_out_t got);
		cell_out_t want;
		if (expected_cells.size() == 0) begin
			mismatch_count++;
			$error("result with nothing expected: row %0d col %0d value %0d",
				got.row_index, got.col_index, got.new_value);
		end else begin
			want = expected_cells.pop_front();
			compare_field("new_value", want.new_value, got.new_value);
			compare_field("row_index", want.row_index, got.row_index);
			compare_field("col_index", want.col_index, got.col_index);
			compare_field("frame_last", want.frame_last, got.frame_last);
		end
	endtask

	// sample all ports at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cfg = GRID_AT_RESET;
			gain_cfg = GAIN_AT_RESET;
			foreach (row_up[i]) begin
				row_up[i] = '0;
				row_mid[i] = '0;
			end
			held_centre = '0;
			held_east = '0;
			next_row = 0;
			next_col = 0;
			expected_cells.delete();
			mismatch_count = 0;
		end else begin
			if (out_valid && out_ready) check_result(out_data);
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRID_SIZE: grid_cfg = cfg_data[POS_W-1:0];
					CFG_GAIN:      gain_cfg = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) stencil_step(in_data);
		end
		results_owed = expected_cells.size();
	end

endmodule

// ===== verif/tb_heat_stencil_jacobi_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heat_stencil_jacobi_step: stimulus and verdict for the heat stencil step
// Streams directed and random padded grids over many grid sizes and gains,
// with random gaps and stalls on both channels and one long output stall.
// Checking is done by hsj_checker; this module reports the verdict.
// ----------------------------------------------------------------------------

module tb_heat_stencil_jacobi_step;
	import hsj_pkg::*;

	localparam int RESET_CYCLES   = 12;
	localparam int FLUSH_CYCLES   = 48;    // queue plus pipeline, with stalls
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEM_TARGET    = 1550;
	localparam int LINE_DEPTH     = 1024;
	localparam int WIDE_CELLS     = LINE_DEPTH + 1;  // clamped padded row plus one cell
	localparam int TAIL_CELLS     = 11;              // rest of row 1, rows 2 and 3 of grid 2
	localparam int LONG_HOLD      = 400;
	localparam int HOLD_GRID      = 8;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	cell_in_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	cell_out_t        out_data;
	logic             cfg_we = 1'b0;
	cfg_index_t       cfg_index = CFG_GRID_SIZE;
	logic [CFG_W-1:0] cfg_data = '0;
	int               mismatch_count;
	int               results_owed;
	int               cells_sent = 0;
	bit               tx_steady = 1'b0;
	bit               hold_req = 1'b0;
	int               idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	heat_stencil_jacobi_step i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hsj_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// cell mix: rails, zero, full range and moderate values
	function automatic logic signed [15:0] pick_cell();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3, 4, 5: return 16'($urandom);
			default: return 16'($urandom_range(0, 4095)) - 16'sd2048;
		endcase
	endfunction

	// offer one item after a random gap and hold it until taken
	task automatic send_cell(input logic signed [15:0] value, input logic mark);
		int gap;
		if ($urandom_range(0, 47) == 0) tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{cell_value: value, frame_start: mark};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		cells_sent++;
	endtask

	task automatic send_cells(input int count, input logic mark);
		for (int i = 0; i < count; i++) send_cell(pick_cell(), mark && i == 0);
	endtask

	// 3x3 padded frame: chosen centre and four neighbors, random corners
	task automatic send_cross(input logic signed [15:0] centre,
			input logic signed [15:0] rim, input logic mark);
		logic signed [15:0] value;
		for (int i = 0; i < 9; i++) begin
			if (i == 4) begin
				value = centre;
			end else if (i % 2 == 1) begin
				value = rim;
			end else begin
				value = pick_cell();
			end
			send_cell(value, mark && i == 0);
		end
	endtask

	// wait for every result, then for cells that cause none to drain
	task automatic drain_block();
		in_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (FLUSH_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// result side: random stalls, stretches of steady ready, one long hold
	initial begin : result_sink
		int wait_cycles;
		bit steady;
		bit held;
		steady = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) steady = !steady;
			wait_cycles = steady ? 0 : $urandom_range(0, 12);
			if (!held && hold_req) begin
				wait_cycles = LONG_HOLD;
				held = 1'b1;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// no item accepted on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int          grid;
		int          side;
		int          nframes;
		int          count;
		logic [15:0] gain;
		bit          must_mark;
		bit          wide_done;
		bit          hold_done;
		must_mark = 1'b0;
		wide_done = 1'b0;
		hold_done = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// smallest grid at reset gain: update lands right on the top rail
		write_reg(CFG_GRID_SIZE, 16'd1);
		send_cross(16'sh8000, 16'sh7FFF, 1'b1);
		drain_block();
		// gain above one, next frame follows the wrap with no start mark
		write_reg(CFG_GAIN, 16'hFFFF);
		send_cross(16'sh7FFF, 16'sh8000, 1'b0);
		drain_block();
		// grid 3, stop in row 2 past the end of a 3-wide padded row
		write_reg(CFG_GRID_SIZE, 16'd3);
		send_cells(14, 1'b1);
		drain_block();
		// grid 0 acts as 1; leftover position wraps column and row
		write_reg(CFG_GRID_SIZE, 16'd0);
		send_cells(9, 1'b0);

		// random phases: one register setting each, mostly whole frames
		while (cells_sent < ITEM_TARGET) begin
			drain_block();
			if (!hold_done && cells_sent > ITEM_TARGET / 5) begin
				// long result hold while a whole frame is offered, so the input stalls
				hold_done = 1'b1;
				write_reg(CFG_GRID_SIZE, 16'(HOLD_GRID));
				write_reg(CFG_GAIN, 16'd8192);
				hold_req = 1'b1;
				send_cells((HOLD_GRID + 2) * (HOLD_GRID + 2), 1'b1);
			end else if (!wide_done && cells_sent > ITEM_TARGET / 3) begin
				// oversize grid clamps to the widest: one padded row and one cell,
				// then grid 2 goes on from row 1 column 1 with no start mark
				wide_done = 1'b1;
				write_reg(CFG_GRID_SIZE, 16'd1023);
				send_cells(WIDE_CELLS, 1'b1);
				drain_block();
				write_reg(CFG_GRID_SIZE, 16'd2);
				send_cells(TAIL_CELLS, 1'b0);
			end else begin
				case ($urandom_range(0, 9))
					0: grid = 0;
					1: grid = 1;
					8: grid = $urandom_range(9, 16);
					9: grid = $urandom_range(17, 24);
					default: grid = $urandom_range(2, 8);
				endcase
				case ($urandom_range(0, 7))
					0: gain = 16'd0;
					1: gain = 16'd32768;
					2: gain = 16'hFFFF;
					3: gain = 16'd8192;
					4: gain = 16'($urandom_range(32769, 65535));
					default: gain = 16'($urandom_range(0, 32768));
				endcase
				write_reg(CFG_GRID_SIZE, 16'(grid));
				write_reg(CFG_GAIN, gain);
				side = ((grid == 0) ? 1 : grid) + 2;
				nframes = (side > 12) ? 1 : $urandom_range(1, 3);
				must_mark = 1'b1;
				for (int f = 0; f < nframes; f++) begin
					// now and then a frame is cut short and restarted
					count = side * side;
					if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count - 1);
					send_cells(count, must_mark || $urandom_range(0, 1) == 1);
					must_mark = (count < side * side);
				end
			end
		end

		drain_block();
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/hsj_pkg.sv
hdl/hsj_front.sv
hdl/hsj_queue.sv
hdl/hsj_back.sv
hdl/heat_stencil_jacobi_step.sv
verif/hsj_checker.sv
verif/tb_heat_stencil_jacobi_step.sv
